>>> src/bms_pkg.sv
// Package for the bump map shader: widths, constants, payload and queue types.
// No dependencies; bms_front, bms_queue, bms_back and the core import it.
`timescale 1ns / 1ps
package bms_pkg;
    localparam int IMAGE_WIDTH     = 320;
    localparam int IMAGE_HEIGHT    = 200;
    localparam int LIGHT_FRAC_BITS = 4;
    localparam int STORE_DEPTH     = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int X_W             = 9;
    localparam int Y_W             = 8;
    localparam int H_W             = 8;
    // signed h components: |2N|*2^F + coords stays well inside 18 bits
    localparam int HV_W            = 18;
    localparam int SQ_W            = 2 * HV_W;
    localparam int ROOT_W          = SQ_W / 2;
    localparam int LEV_W           = 20;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_RENDER = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [12:0]    light_x;
        logic [11:0]    light_y;
        logic [2:0]     noise;
    } render_req_t;

    typedef struct packed
    {
        logic            wr_en;
        logic [ADDR_W-1:0] addr;
        logic [H_W-1:0]  data;
    } store_wr_t;
endpackage

>>> src/bms_if.sv
// Valid/ready stream interfaces for requests and results.
// No dependencies.
`timescale 1ns / 1ps
interface bms_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] height_value;
    logic [12:0] light_x;
    logic [11:0] light_y;
    logic [2:0] texture_noise;
    modport source (output valid, command, pixel_x, pixel_y, height_value,
                    light_x, light_y, texture_noise, input ready);
    modport sink (input valid, command, pixel_x, pixel_y, height_value,
                  light_x, light_y, texture_noise, output ready);
endinterface

interface bms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] intensity;
    logic [8:0] out_x;
    logic [7:0] out_y;
    modport source (output valid, intensity, out_x, out_y, input ready);
    modport sink (input valid, intensity, out_x, out_y, output ready);
endinterface

>>> src/bms_front.sv
// Front end: accept requests, range check, split loads from renders.
// Depends on bms_pkg and bms_if.
`timescale 1ns / 1ps
module bms_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    bms_in_if.sink                in_ch,
    input  logic                  q_full,
    input  logic                  q_not_empty,
    output logic                  q_push,
    output bms_pkg::render_req_t  q_data,
    output bms_pkg::store_wr_t    wr
);
    import bms_pkg::*;

    logic in_range;
    logic accept;

    assign in_range = ({1'b0, in_ch.pixel_x} < 10'(IMAGE_WIDTH))
                   && ({1'b0, in_ch.pixel_y} < 9'(IMAGE_HEIGHT));
    // hold loads until queued renders have read the store; renders wait for queue room
    assign in_ch.ready = (in_ch.command == CMD_LOAD) ? !q_not_empty : !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    assign q_push          = accept && in_range && (in_ch.command == CMD_RENDER);
    assign q_data.x        = in_ch.pixel_x;
    assign q_data.y        = in_ch.pixel_y;
    assign q_data.light_x  = in_ch.light_x;
    assign q_data.light_y  = in_ch.light_y;
    assign q_data.noise    = in_ch.texture_noise;

    assign wr.wr_en = accept && in_range && (in_ch.command == CMD_LOAD);
    assign wr.addr  = ADDR_W'(({7'd0, in_ch.pixel_y} * 15'(IMAGE_WIDTH))
                    + {6'd0, in_ch.pixel_x});
    assign wr.data  = in_ch.height_value;
endmodule

>>> src/bms_queue.sv
// Short request queue between front and back.
// Depends on bms_pkg.
`timescale 1ns / 1ps
module bms_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bms_pkg::render_req_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output bms_pkg::render_req_t pop_data
);
    import bms_pkg::*;

    render_req_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

>>> src/bms_back.sv
// Back end: three replicated height memories, normal, h vector, pipelined
// root (one result bit per stage), level and clamp, output register.
// Depends on bms_pkg and bms_if.
`timescale 1ns / 1ps
module bms_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bms_pkg::store_wr_t   wr,
    input  logic                 q_valid,
    input  bms_pkg::render_req_t q_data,
    output logic                 q_pop,
    bms_out_if.source            out_ch
);
    import bms_pkg::*;

    localparam int NST = ROOT_W;
    localparam int PIPE = 3 + NST + 1;

    // one stall line for the whole pipeline
    logic adv;

    logic [H_W-1:0] mem_c [STORE_DEPTH];
    logic [H_W-1:0] mem_r [STORE_DEPTH];
    logic [H_W-1:0] mem_d [STORE_DEPTH];

    logic [X_W-1:0]    xr;
    logic [Y_W-1:0]    yd;
    logic [ADDR_W-1:0] a_c, a_r, a_d;

    // stage 1: memory read
    logic              v1_reg;
    render_req_t       r1_reg;
    logic [H_W-1:0]    hc_reg, hr_reg, hd_reg;
    // stage 2: h vector
    logic              v2_reg;
    render_req_t       r2_reg;
    logic signed [HV_W-1:0] hx_reg, hy_reg;
    // stage 3: squares summed
    logic              v3_reg;
    render_req_t       r3_reg;
    logic [SQ_W-1:0]   sq_reg;
    // root stages
    logic              vs_reg [NST+1];
    render_req_t       rs_reg [NST+1];
    logic [SQ_W-1:0]   rem_reg [NST+1];
    logic [ROOT_W-1:0] root_reg [NST+1];
    // output
    logic              ov_reg;
    logic [7:0]        oint_reg;
    logic [X_W-1:0]    ox_reg;
    logic [Y_W-1:0]    oy_reg;

    assign adv   = !ov_reg || out_ch.ready;
    assign q_pop = adv && q_valid;

    assign xr  = (q_data.x == X_W'(IMAGE_WIDTH - 1)) ? '0 : q_data.x + 1'b1;
    assign yd  = (q_data.y == Y_W'(IMAGE_HEIGHT - 1)) ? '0 : q_data.y + 1'b1;
    assign a_c = ADDR_W'(({7'd0, q_data.y} * 15'(IMAGE_WIDTH)) + {6'd0, q_data.x});
    assign a_r = ADDR_W'(({7'd0, q_data.y} * 15'(IMAGE_WIDTH)) + {6'd0, xr});
    assign a_d = ADDR_W'(({7'd0, yd} * 15'(IMAGE_WIDTH)) + {6'd0, q_data.x});

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem_c[wr.addr] <= wr.data;
            mem_r[wr.addr] <= wr.data;
            mem_d[wr.addr] <= wr.data;
        end
        if (adv)
        begin
            hc_reg <= mem_c[a_c];
            hr_reg <= mem_r[a_r];
            hd_reg <= mem_d[a_d];
        end
    end

    logic signed [HV_W-1:0] nx, ny, hx_c, hy_c;
    logic [SQ_W-1:0] sq_c;
    always_comb
    begin
        nx   = HV_W'($signed({1'b0, hc_reg})) - HV_W'($signed({1'b0, hr_reg}));
        ny   = HV_W'($signed({1'b0, hc_reg})) - HV_W'($signed({1'b0, hd_reg}));
        hx_c = (nx <<< (LIGHT_FRAC_BITS + 1)) - $signed(HV_W'(r1_reg.light_x))
             + $signed(HV_W'(r1_reg.x) << LIGHT_FRAC_BITS);
        hy_c = (ny <<< (LIGHT_FRAC_BITS + 1)) - $signed(HV_W'(r1_reg.light_y))
             + $signed(HV_W'(r1_reg.y) << LIGHT_FRAC_BITS);
        sq_c = SQ_W'(hx_reg * hx_reg) + SQ_W'(hy_reg * hy_reg);
    end

    // restoring root, one bit per stage
    logic [SQ_W-1:0]   rem_n [NST];
    logic [ROOT_W-1:0] root_n [NST];
    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            logic [SQ_W-1:0] trial;
            trial = (SQ_W'(root_reg[k]) << (NST - k)) | (SQ_W'(1) << (2*(NST-1-k)));
            if (rem_reg[k] >= trial)
            begin
                rem_n[k]  = rem_reg[k] - trial;
                root_n[k] = root_reg[k] | (ROOT_W'(1) << (NST-1-k));
            end
            else
            begin
                rem_n[k]  = rem_reg[k];
                root_n[k] = root_reg[k];
            end
        end
    end

    logic signed [LEV_W-1:0] lev;
    logic [7:0] q_c;
    always_comb
    begin
        lev = $signed(LEV_W'(9'd256 + {6'd0, rs_reg[NST].noise}) << LIGHT_FRAC_BITS)
            - $signed(LEV_W'(root_reg[NST]));
        if (lev < $signed(LEV_W'(1) << LIGHT_FRAC_BITS))
            q_c = 8'd1;
        else if ((lev >>> LIGHT_FRAC_BITS) > $signed(LEV_W'(254)))
            q_c = 8'd254;
        else
            q_c = 8'(lev >>> LIGHT_FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k <= NST; k++) vs_reg[k] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= q_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vs_reg[0] <= v3_reg;
            for (int k = 0; k < NST; k++) vs_reg[k+1] <= vs_reg[k];
            ov_reg    <= vs_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg      <= q_data;
            r2_reg      <= r1_reg;
            hx_reg      <= hx_c;
            hy_reg      <= hy_c;
            r3_reg      <= r2_reg;
            sq_reg      <= sq_c;
            rs_reg[0]   <= r3_reg;
            rem_reg[0]  <= sq_reg;
            root_reg[0] <= '0;
            for (int k = 0; k < NST; k++)
            begin
                rs_reg[k+1]   <= rs_reg[k];
                rem_reg[k+1]  <= rem_n[k];
                root_reg[k+1] <= root_n[k];
            end
            oint_reg <= q_c;
            ox_reg   <= rs_reg[NST].x;
            oy_reg   <= rs_reg[NST].y;
        end
    end

    assign out_ch.valid     = ov_reg;
    assign out_ch.intensity = oint_reg;
    assign out_ch.out_x     = ox_reg;
    assign out_ch.out_y     = oy_reg;
endmodule

>>> src/bump_map_shader_core.sv
// A render result passes the queue, memory read, h vector, squares, 18 root stages
// and the clamp register. Renders are taken at one per cycle while the output
// is not stalled; a load waits while renders sit in the queue. Output stalls
// hold the whole back pipeline.
// Reset clears all valid state; the height memories are not cleared.
// Depends on bms_pkg, bms_if, bms_front, bms_queue, bms_back.
`timescale 1ns / 1ps
module bump_map_shader_core
(
    input  logic       clk,
    input  logic       rst_n,
    bms_in_if.sink     in_ch,
    bms_out_if.source  out_ch
);
    import bms_pkg::*;

    logic        q_full, q_push, q_pop, q_ne;
    render_req_t q_in, q_out;
    store_wr_t   wr;

    bms_front u_front (.clk, .rst_n, .in_ch, .q_full, .q_not_empty(q_ne), .q_push,
                       .q_data(q_in), .wr);
    bms_queue u_queue (.clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
                       .pop(q_pop), .not_empty(q_ne), .pop_data(q_out));
    bms_back  u_back (.clk, .rst_n, .wr, .q_valid(q_ne), .q_data(q_out), .q_pop, .out_ch);
endmodule

>>> src/bms_checker.sv
// Port-level checks on the shader core; bound to the top level.
// Depends on bms_if.
`timescale 1ns / 1ps
module bms_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_command,
    input logic out_valid,
    input logic out_ready,
    input logic [7:0] intensity
);
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (intensity >= 8'd1 && intensity <= 8'd254))
        else $error("intensity out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(intensity))
        else $error("stalled result changed");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown({in_command, in_ready}))
        else $error("request handshake unknown");
    a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result during reset");
endmodule

bind bump_map_shader_core bms_checker u_chk (.clk, .rst_n, .in_valid(in_ch.valid),
    .in_ready(in_ch.ready), .in_command(in_ch.command), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .intensity(out_ch.intensity));
